### sv/refraction_fresnel_unit_defines.svh
// ----------------------------------------------------------------------------
// refraction_fresnel_unit_defines.svh
// assertion macros shared by the refraction and fresnel unit
// ----------------------------------------------------------------------------
`ifndef REFRACTION_FRESNEL_UNIT_DEFINES_SVH
`define REFRACTION_FRESNEL_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define RFU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked a fixed number of cycles later
`define RFU_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

### sv/rfu_pkg.sv
// ----------------------------------------------------------------------------
// rfu_pkg
// widths, constants and helpers of the refraction and fresnel unit
// ----------------------------------------------------------------------------
package rfu_pkg;

	// default vector width, signed q2.14
	localparam int VEC_WIDTH_DEF = 16;

	// index of refraction, unsigned q2.13
	localparam int IOR_WIDTH = 15;
	localparam logic [IOR_WIDTH-1:0] IOR_ONE = 15'd8192;

	// fresnel weight, unsigned q1.15
	localparam int W_WIDTH = 16;
	localparam logic [W_WIDTH-1:0] Q15_ONE = 16'd32768;

	// cosines and sines in q.16
	localparam int Q16_WIDTH = 17;
	localparam logic [Q16_WIDTH-1:0] Q16_ONE = 17'd65536;

	// eta in q.16, 2^29 / index when entering
	localparam int ETA_QBITS = 29;
	localparam int ETA_WIDTH = ETA_QBITS + 1;

	// eta squared, clamped where it forces total internal reflection anyway
	localparam int E2_WIDTH = 34;
	localparam logic [E2_WIDTH-1:0] E2_MAX = 34'h2_0000_0000;

	// k = 1 - eta^2 sin^2 in q.32 and its root in q.16
	localparam int K_WIDTH = 33;
	localparam logic [K_WIDTH-1:0] K_ONE = 33'h1_0000_0000;
	localparam int SK_WIDTH = 17;

	// normal coefficient in q.16
	localparam int M_WIDTH = 32;

	// schlick divider: |1 - n| / (1 + n)
	localparam int FR_DEN_WIDTH = 16;
	localparam int FR_QBITS = 15;

	// quotient or root bits resolved per pipeline stage
	localparam int DIV_STEPS = 8;
	localparam int SQRT_STEPS = 6;

	// q1.15 product, rounded half up
	function automatic logic [W_WIDTH-1:0] mul_q15(input logic [W_WIDTH-1:0] a,
		input logic [W_WIDTH-1:0] b);
		logic [2*W_WIDTH-1:0] p;
		p = (2*W_WIDTH)'(a) * (2*W_WIDTH)'(b) + (2*W_WIDTH)'(16384);
		return W_WIDTH'(p >> 15);
	endfunction

endpackage

### sv/rfu_div.sv
// ----------------------------------------------------------------------------
// rfu_div
// pipelined restoring divider, q = floor(a * 2^QB / b) for a <= b
// ----------------------------------------------------------------------------
module rfu_div #(
	parameter int DW = 16,
	parameter int QB = 15,
	parameter int STEPS = 8
) (
	input  logic          clk,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic [QB:0]   q
);

	localparam int NSTG = (QB + STEPS) / STEPS;

	logic [DW:0]   rem_s [NSTG];
	logic [DW-1:0] den_s [NSTG];
	logic [QB:0]   quo_s [NSTG];

	genvar g;
	for (g = 0; g < NSTG; g++) begin : g_stg
		logic [DW:0]   rem_in;
		logic [DW:0]   rem_nx;
		logic [DW-1:0] den_in;
		logic [QB:0]   quo_in;
		logic [QB:0]   quo_nx;

		if (g == 0) begin : g_first
			assign rem_in = {1'b0, a};
			assign den_in = b;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[g-1];
			assign den_in = den_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		// one quotient bit per step, msb first
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int t = 0; t < STEPS; t++) begin
				if (QB - g*STEPS - t >= 0) begin
					if (rem_nx >= {1'b0, den_in}) begin
						rem_nx = rem_nx - {1'b0, den_in};
						quo_nx[QB - g*STEPS - t] = 1'b1;
					end
					rem_nx = {rem_nx[DW-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_nx;
			den_s[g] <= den_in;
			quo_s[g] <= quo_nx;
		end
	end

	assign q = quo_s[NSTG-1];

endmodule

### sv/rfu_isqrt.sv
// ----------------------------------------------------------------------------
// rfu_isqrt
// pipelined floor integer square root, one root bit per step
// ----------------------------------------------------------------------------
module rfu_isqrt #(
	parameter int XW = 33,
	parameter int RW = 17,
	parameter int STEPS = 6
) (
	input  logic          clk,
	input  logic [XW-1:0] x,
	output logic [RW-1:0] root
);

	localparam int NSTG = (RW + STEPS - 1) / STEPS;
	localparam int AW = 2 * RW + 1;

	logic [AW-1:0] rad_s [NSTG];
	logic [AW-1:0] res_s [NSTG];

	genvar g;
	for (g = 0; g < NSTG; g++) begin : g_stg
		logic [AW-1:0] rad_in;
		logic [AW-1:0] res_in;
		logic [AW-1:0] rad_nx;
		logic [AW-1:0] res_nx;
		logic [AW-1:0] bit_w;

		if (g == 0) begin : g_first
			assign rad_in = AW'(x);
			assign res_in = '0;
		end else begin : g_rest
			assign rad_in = rad_s[g-1];
			assign res_in = res_s[g-1];
		end

		// digit by digit, test bit falls by four each step
		always_comb begin
			rad_nx = rad_in;
			res_nx = res_in;
			bit_w = '0;
			for (int t = 0; t < STEPS; t++) begin
				if (g*STEPS + t < RW) begin
					bit_w = AW'(1) << (2 * (RW - 1 - g*STEPS - t));
					if (rad_nx >= res_nx + bit_w) begin
						rad_nx = rad_nx - (res_nx + bit_w);
						res_nx = (res_nx >> 1) + bit_w;
					end else begin
						res_nx = res_nx >> 1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			rad_s[g] <= rad_nx;
			res_s[g] <= res_nx;
		end
	end

	assign root = RW'(res_s[NSTG-1]);

endmodule

### sv/refraction_fresnel_unit.sv
// ----------------------------------------------------------------------------
// refraction_fresnel_unit
// mirror and snell directions plus schlick fresnel weight for one hit
// ----------------------------------------------------------------------------
// A hit word is taken on any cycle with start high; busy is always low, so a
// new word may follow every cycle. Each result comes out once its word has
// passed the whole pipeline, marked by done for one cycle, in input order.
// The pipeline runs as follows: the dot product and reflection
// take four stages, the 30-bit eta division runs four stages alongside them,
// then eta products, the k term, a three-stage square root and the final
// refraction products and saturation follow. Results cannot be held off.
module refraction_fresnel_unit #(
	parameter int VEC_WIDTH = rfu_pkg::VEC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [VEC_WIDTH-1:0]     dir_x,
	input  logic signed [VEC_WIDTH-1:0]     dir_y,
	input  logic signed [VEC_WIDTH-1:0]     dir_z,
	input  logic signed [VEC_WIDTH-1:0]     norm_x,
	input  logic signed [VEC_WIDTH-1:0]     norm_y,
	input  logic signed [VEC_WIDTH-1:0]     norm_z,
	input  logic [rfu_pkg::IOR_WIDTH-1:0]   index_of_refraction,
	output logic                            done,
	output logic signed [VEC_WIDTH-1:0]     refl_x,
	output logic signed [VEC_WIDTH-1:0]     refl_y,
	output logic signed [VEC_WIDTH-1:0]     refl_z,
	output logic signed [VEC_WIDTH-1:0]     refr_x,
	output logic signed [VEC_WIDTH-1:0]     refr_y,
	output logic signed [VEC_WIDTH-1:0]     refr_z,
	output logic [rfu_pkg::W_WIDTH-1:0]     fresnel_weight,
	output logic                            total_internal
);

`include "refraction_fresnel_unit_defines.svh"

	localparam int NSTG = 14;
	localparam int VF = VEC_WIDTH - 2;
	localparam int UP = (VF < 16) ? 16 - VF : 0;
	localparam int DN = (VF > 16) ? VF - 16 : 0;
	localparam int PW = 2 * VEC_WIDTH;
	localparam int SATW = VEC_WIDTH + 20;
	localparam int IW = rfu_pkg::IOR_WIDTH;
	localparam int WW = rfu_pkg::W_WIDTH;
	localparam int QW = rfu_pkg::Q16_WIDTH;
	localparam int EW = rfu_pkg::ETA_WIDTH;
	localparam int C2W = 2 * QW;
	localparam int E2RW = 2 * EW;
	localparam int E2W = rfu_pkg::E2_WIDTH;
	localparam int PRW = E2W + QW;
	localparam int KW = rfu_pkg::K_WIDTH;
	localparam int SKW = rfu_pkg::SK_WIDTH;
	localparam int MW = rfu_pkg::M_WIDTH;
	localparam int ECRW = EW + QW;
	localparam int EDW = VEC_WIDTH + EW + 1;
	localparam int NPW = VEC_WIDTH + MW + 1;
	localparam int NVW = NPW + 1;
	localparam int FDW = rfu_pkg::FR_DEN_WIDTH;

	localparam logic signed [SATW-1:0] VMAX = SATW'((64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SATW-1:0] VMIN = -VMAX - SATW'(1);
	localparam logic [VEC_WIDTH-1:0] ONE_V = VEC_WIDTH'(1) << VF;

	typedef logic signed [VEC_WIDTH-1:0] vec_t;

	function automatic vec_t sat_vec(input logic signed [SATW-1:0] v);
		if (v > VMAX) begin
			return VEC_WIDTH'(VMAX);
		end else if (v < VMIN) begin
			return VEC_WIDTH'(VMIN);
		end
		return VEC_WIDTH'(v);
	endfunction

	logic             accept;
	vec_t             din [3];
	vec_t             nin [3];
	logic [NSTG:1]    vld_s;

	// delay lines, indexed by stage
	vec_t             d_s    [1:5][3];
	vec_t             n_s    [1:12][3];
	logic [IW-1:0]    ior_s  [1:4];
	logic             ent_s  [3:13];
	logic [QW-1:0]    c16_s  [3:5];
	logic [WW-1:0]    r0_s   [3:8];
	logic [WW-1:0]    x_s    [4:6];
	logic [QW-1:0]    s2_s   [5:6];
	logic [EW-1:0]    ec_s   [6:11];
	logic signed [EDW-1:0] ed_s [6:13][3];
	logic             tir_s  [8:14];
	vec_t             refl_s [4:14][3];
	logic [WW-1:0]    w_s    [9:14];
	vec_t             refr_s14 [3];

	// single stage registers
	logic signed [PW-1:0]  pdn_s1 [3];
	vec_t                  dot_s2;
	logic signed [PW-1:0]  pnd_s3 [3];
	logic [C2W-1:0]        c16sq_s4;
	logic [EW-1:0]         eta_s5;
	logic [WW-1:0]         x2_s5;
	logic [E2W-1:0]        e2_s6;
	logic [WW-1:0]         x4_s6;
	logic [PRW-1:0]        prod_s7;
	logic [WW-1:0]         x5_s7;
	logic [KW-1:0]         k_s8;
	logic [WW-1:0]         wm_s8;
	logic [MW-1:0]         m16_s12;
	logic signed [NPW-1:0] npm_s13 [3];

	// combinational helpers
	logic [IW-1:0]         eta_den;
	logic [IW-1:0]         fr_num;
	logic [FDW-1:0]        fr_den;
	logic [EW-1:0]         eta_q;
	logic [WW-1:0]         r_q;
	logic [SKW-1:0]        sk;
	logic signed [SATW-1:0] dsum;
	logic [VEC_WIDTH-1:0]  cabs;
	logic [VEC_WIDTH-1:0]  cclip;
	logic [QW-1:0]         c16;
	logic [E2RW-1:0]       e2raw;
	logic [E2RW-1:0]       e2sh;
	logic [ECRW-1:0]       ecraw;
	logic [WW:0]           wsum;

	assign accept = start && !busy;
	assign busy = 1'b0;

	assign din = '{dir_x, dir_y, dir_z};
	assign nin = '{norm_x, norm_y, norm_z};

	// divider operands, index zero acts as the smallest code for eta
	assign eta_den = (index_of_refraction == '0) ? IW'(1) : index_of_refraction;
	assign fr_num = (index_of_refraction > rfu_pkg::IOR_ONE) ?
		index_of_refraction - rfu_pkg::IOR_ONE : rfu_pkg::IOR_ONE - index_of_refraction;
	assign fr_den = FDW'(index_of_refraction) + FDW'(rfu_pkg::IOR_ONE);

	// eta = 2^29 / index, ready with stage 4
	rfu_div #(
		.DW    (IW),
		.QB    (rfu_pkg::ETA_QBITS),
		.STEPS (rfu_pkg::DIV_STEPS)
	) u_eta_div (
		.clk (clk),
		.a   (IW'(1)),
		.b   (eta_den),
		.q   (eta_q)
	);

	// schlick ratio |1 - n| / (1 + n), ready with stage 2
	rfu_div #(
		.DW    (FDW),
		.QB    (rfu_pkg::FR_QBITS),
		.STEPS (rfu_pkg::DIV_STEPS)
	) u_fr_div (
		.clk (clk),
		.a   (FDW'(fr_num)),
		.b   (fr_den),
		.q   (r_q)
	);

	// sqrt(k), stages 9 to 11
	rfu_isqrt #(
		.XW    (KW),
		.RW    (SKW),
		.STEPS (rfu_pkg::SQRT_STEPS)
	) u_isqrt (
		.clk  (clk),
		.x    (k_s8),
		.root (sk)
	);

	// dot product sum, cosine and its q.16 form, eta products and weight sum
	always_comb begin
		dsum = SATW'(pdn_s1[0] >>> VF) + SATW'(pdn_s1[1] >>> VF) + SATW'(pdn_s1[2] >>> VF);
		cabs = dot_s2[VEC_WIDTH-1] ? VEC_WIDTH'(-dot_s2) : VEC_WIDTH'(dot_s2);
		cclip = (cabs > ONE_V) ? ONE_V : cabs;
		c16 = QW'((64'(cclip) << UP) >> DN);
		e2raw = E2RW'(eta_s5) * E2RW'(eta_s5);
		e2sh = e2raw >> 16;
		ecraw = ECRW'(eta_s5) * ECRW'(c16_s[5]);
		wsum = {1'b0, r0_s[8]} + {1'b0, wm_s8};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NSTG-1:1], accept};
		end
	end

	// stages 1 to 9 and the carried fields
	always_ff @(posedge clk) begin
		// stages 1 to 4: products, dot, reflection
		for (int i = 0; i < 3; i++) begin
			pdn_s1[i] <= PW'(din[i]) * PW'(nin[i]);
			pnd_s3[i] <= PW'(n_s[2][i]) * PW'(dot_s2);
			refl_s[4][i] <= sat_vec(SATW'(d_s[3][i]) - (SATW'(pnd_s3[i] >>> VF) <<< 1));
		end
		d_s[1] <= din;
		n_s[1] <= nin;
		ior_s[1] <= index_of_refraction;
		for (int k = 2; k <= 5; k++) begin
			d_s[k] <= d_s[k-1];
		end
		for (int k = 2; k <= 12; k++) begin
			n_s[k] <= n_s[k-1];
		end
		for (int k = 2; k <= 4; k++) begin
			ior_s[k] <= ior_s[k-1];
		end
		dot_s2 <= sat_vec(dsum);
		ent_s[3] <= dot_s2[VEC_WIDTH-1];
		c16_s[3] <= c16;
		r0_s[3] <= rfu_pkg::mul_q15(r_q, r_q);
		c16sq_s4 <= C2W'(c16_s[3]) * C2W'(c16_s[3]);
		x_s[4] <= rfu_pkg::Q15_ONE - WW'(c16_s[3] >> 1);

		// stages 5 to 9: eta terms, k, fresnel chain
		eta_s5 <= ent_s[4] ? eta_q : EW'({ior_s[4], 3'b000});
		s2_s[5] <= rfu_pkg::Q16_ONE - QW'(c16sq_s4 >> 16);
		x2_s5 <= rfu_pkg::mul_q15(x_s[4], x_s[4]);
		e2_s6 <= (e2sh > E2RW'(rfu_pkg::E2_MAX)) ? rfu_pkg::E2_MAX : E2W'(e2sh);
		ec_s[6] <= EW'(ecraw >> 16);
		for (int i = 0; i < 3; i++) begin
			ed_s[6][i] <= EDW'($signed({1'b0, eta_s5})) * EDW'(d_s[5][i]);
		end
		x4_s6 <= rfu_pkg::mul_q15(x2_s5, x2_s5);
		prod_s7 <= PRW'(e2_s6) * PRW'(s2_s[6]);
		x5_s7 <= rfu_pkg::mul_q15(x4_s6, x_s[6]);
		tir_s[8] <= prod_s7 > PRW'(rfu_pkg::K_ONE);
		k_s8 <= KW'(PRW'(rfu_pkg::K_ONE) - prod_s7);
		wm_s8 <= rfu_pkg::mul_q15(rfu_pkg::Q15_ONE - r0_s[7], x5_s7);
		w_s[9] <= (wsum > (WW + 1)'(rfu_pkg::Q15_ONE)) ? rfu_pkg::Q15_ONE : WW'(wsum);

		// carried fields
		for (int k = 4; k <= 13; k++) begin
			ent_s[k] <= ent_s[k-1];
		end
		for (int k = 4; k <= 5; k++) begin
			c16_s[k] <= c16_s[k-1];
		end
		for (int k = 4; k <= 8; k++) begin
			r0_s[k] <= r0_s[k-1];
		end
		for (int k = 5; k <= 6; k++) begin
			x_s[k] <= x_s[k-1];
		end
		s2_s[6] <= s2_s[5];
		for (int k = 7; k <= 11; k++) begin
			ec_s[k] <= ec_s[k-1];
		end
		for (int k = 7; k <= 13; k++) begin
			ed_s[k] <= ed_s[k-1];
		end
		for (int k = 9; k <= 14; k++) begin
			tir_s[k] <= tir_s[k-1];
		end
		for (int k = 5; k <= 14; k++) begin
			refl_s[k] <= refl_s[k-1];
		end
		for (int k = 10; k <= 14; k++) begin
			w_s[k] <= w_s[k-1];
		end
	end

	// stages 12 to 14: normal coefficient, refraction, output
	always_ff @(posedge clk) begin
		m16_s12 <= MW'(ec_s[11]) + MW'(sk);
		for (int i = 0; i < 3; i++) begin
			npm_s13[i] <= NPW'(n_s[12][i]) * NPW'($signed({1'b0, m16_s12}));
			refr_s14[i] <= tir_s[13] ? '0 : sat_vec(SATW'(ed_s[13][i] >>> 16)
				- SATW'((ent_s[13] ? NVW'(npm_s13[i]) : -NVW'(npm_s13[i])) >>> 16));
		end
	end

	// result word
	assign done = vld_s[NSTG];
	assign refl_x = refl_s[14][0];
	assign refl_y = refl_s[14][1];
	assign refl_z = refl_s[14][2];
	assign refr_x = refr_s14[0];
	assign refr_y = refr_s14[1];
	assign refr_z = refr_s14[2];
	assign fresnel_weight = w_s[14];
	assign total_internal = tir_s[14];

	// checks
	`RFU_ASSERT_DLY(a_latency, start && !busy, NSTG, done, "word taken but no result after latency")
	`RFU_ASSERT_IMP(a_done_src, done, $past(start && !busy, NSTG), "result without a word taken")
	`RFU_ASSERT_IMP(a_tir_zero, done && total_internal, refr_x == '0 && refr_y == '0 && refr_z == '0, "refraction not zero on total internal reflection")
	`RFU_ASSERT_IMP(a_weight_range, done, fresnel_weight <= rfu_pkg::Q15_ONE, "fresnel weight above one")

endmodule
